// File: design/energy_band_particle_id_top_macros.svh
// ----------------------------------------------------------------------------
// energy_band_particle_id_top_macros
// assertion macros used by the checker file of the band cut block
// ----------------------------------------------------------------------------
`ifndef ENERGY_BAND_PARTICLE_ID_TOP_MACROS_SVH
`define ENERGY_BAND_PARTICLE_ID_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define EBPID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ebpid check failed");

// next-cycle implication, disabled while reset is low
`define EBPID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ebpid check failed");

`endif

// File: design/ebpid_pkg.sv
// ----------------------------------------------------------------------------
// ebpid_pkg
// constants, band tables and shared types of the band cut particle id block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ebpid_pkg;

    localparam int TABLE_POINTS = 84;
    localparam int IDX_W        = 7;
    localparam int ENERGY_W     = 14;
    localparam int CUT_W        = 11;
    localparam int SPAN_W       = 9;
    localparam int STEP_W       = 3;
    localparam int NUM_W        = 20;
    localparam int QUO_W        = 14;
    localparam int LOSS_W       = 12;
    localparam int CALO_W       = 15;
    localparam int OFS_W        = 16;
    localparam int FRAC_SHIFT   = 6;
    localparam int CENT_DIV     = 100;

    typedef int unsigned t_tab [TABLE_POINTS];

    localparam t_tab PT_MEV = '{
        1, 3, 5, 7, 9, 11, 13, 15, 17, 19,
        21, 23, 25, 27, 29, 31, 33, 35, 37, 39,
        41, 43, 45, 47, 49, 51, 53, 55, 57, 59,
        61, 63, 65, 67, 69, 71, 73, 75, 77, 79,
        81, 83, 85, 87, 89, 91, 93, 95, 97, 99,
        101, 103, 105, 107, 109, 111, 113, 115, 117, 119,
        121, 123, 125, 127, 129, 131, 133, 135, 137, 139,
        141, 143, 145, 147, 149, 151, 153, 155, 157, 160,
        164, 168, 173, 179};

    localparam t_tab LO_CENT = '{
        184, 204, 213, 202, 189, 181, 173, 163, 159, 152,
        147, 138, 134, 125, 125, 121, 114, 110, 106, 103,
        98, 96, 91, 90, 90, 86, 83, 80, 79, 76,
        77, 74, 72, 74, 70, 66, 65, 62, 62, 61,
        61, 60, 61, 55, 56, 53, 50, 53, 52, 52,
        54, 49, 45, 51, 50, 49, 47, 46, 46, 49,
        41, 43, 45, 43, 41, 39, 39, 42, 41, 39,
        39, 38, 37, 37, 36, 37, 41, 37, 37, 37,
        37, 37, 37, 37};

    localparam t_tab HI_CENT = '{
        550, 458, 411, 376, 355, 331, 314, 297, 276, 259,
        247, 239, 226, 220, 204, 197, 192, 186, 179, 173,
        168, 163, 160, 155, 148, 145, 142, 139, 134, 133,
        127, 126, 125, 119, 119, 118, 114, 114, 111, 109,
        107, 105, 102, 104, 101, 103, 102, 95, 96, 93,
        89, 92, 94, 88, 86, 85, 87, 87, 85, 82,
        85, 83, 79, 80, 81, 83, 82, 76, 77, 75,
        75, 75, 75, 75, 73, 73, 71, 73, 73, 73,
        73, 73, 73, 73};

    // hundredths to 1/256, rounded half up, evaluated at elaboration
    function automatic t_tab to_q8_tab(t_tab cent);
        t_tab q;
        for (int k = 0; k < TABLE_POINTS; k++) begin
            q[k] = (cent[k] * 256 + 50) / CENT_DIV;
        end
        return q;
    endfunction

    localparam t_tab LO_Q8 = to_q8_tab(LO_CENT);
    localparam t_tab HI_Q8 = to_q8_tab(HI_CENT);

    localparam logic [IDX_W-1:0] FIRST_IDX = '0;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_POINTS - 1);

    // table point energy in 1/64 MeV
    function automatic logic [ENERGY_W-1:0] energy_at(input logic [IDX_W-1:0] idx);
        return ENERGY_W'(PT_MEV[idx] * 64);
    endfunction

    // segment width in whole MeV
    function automatic logic [STEP_W-1:0] step_at(input logic [IDX_W-1:0] idx);
        return STEP_W'(PT_MEV[idx] - PT_MEV[idx - IDX_W'(1)]);
    endfunction

    function automatic logic [CUT_W-1:0] cut_at(input logic [IDX_W-1:0] idx,
                                                input logic upper);
        logic [CUT_W-1:0] v;
        v = upper ? CUT_W'(HI_Q8[idx]) : CUT_W'(LO_Q8[idx]);
        return v;
    endfunction

    // request to the iterative divider
    typedef struct packed {
        logic              start;
        logic [QUO_W-1:0]  dividend;
        logic [STEP_W-1:0] divisor;
    } t_div_req;

endpackage

// File: design/ebpid_divider.sv
// ----------------------------------------------------------------------------
// ebpid_divider
// restoring divider, one quotient bit per cycle, small divisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebpid_divider
    import ebpid_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [STEP_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [STEP_W:0]   rem_sh;
    logic              fits;
    logic [STEP_W:0]   rem_sub;

    // trial subtract of the shifted remainder
    always_comb begin
        rem_sh  = {r_rem, r_quo[QUO_W-1]};
        fits    = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[STEP_W-1:0] : rem_sh[STEP_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: design/energy_band_particle_id_top.sv
// ----------------------------------------------------------------------------
// energy_band_particle_id_top
// band cut particle id: interpolated cuts, proton and pion flags, band offset
// ----------------------------------------------------------------------------
// usage
//   slave channel: one transfer carries calo_energy (bits 14:0, signed,
//   1/64 MeV) and fiber_loss (bits 26:15, 1/256)
//   master channel: one transfer per input with is_proton (bit 0), is_pion
//   (bit 1) and band_offset (bits 17:2, signed)
//   search over the point table, then each cut takes two multiply steps,
//   a divider start and a wait for the divider; an item outside the table
//   range skips these steps and goes straight to the done step
//   o_s_tready is high only while the sequencer is idle
//   a finished result sits in the output register; the next item may be
//   accepted meanwhile but completes only after the register is taken
//   a stalled receiver keeps the result stable until it takes it
//   reset empties the output register and returns the sequencer to idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module energy_band_particle_id_top
    import ebpid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // calo_energy[14:0], fiber_loss[26:15], zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // is_proton[0], is_pion[1], band_offset[17:2], zero
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MUL0,
        S_MUL1,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic signed [CALO_W-1:0]   r_e;
    logic [ENERGY_W-1:0]        r_u;
    logic [LOSS_W-1:0]          r_loss;
    logic [IDX_W-1:0]           r_lo_idx;
    logic [IDX_W-1:0]           r_hi_idx;
    logic [SPAN_W-1:0]          r_a;
    logic [SPAN_W-1:0]          r_b;
    logic [STEP_W-1:0]          r_k;
    logic [NUM_W-1:0]           r_acc;
    logic                       r_pass;
    logic [CUT_W-1:0]           r_lo_cut;
    logic [CUT_W-1:0]           r_hi_cut;
    logic                       r_out_valid;
    logic [23:0]                r_out_data;

    logic                       in_xfer;
    logic                       out_xfer;
    logic signed [CALO_W-1:0]   in_e;
    logic [IDX_W:0]             mid_sum;
    logic [IDX_W-1:0]           mid;
    logic [IDX_W-1:0]           seg_lo;
    logic [CUT_W-1:0]           c0;
    logic [CUT_W-1:0]           c1;
    logic [SPAN_W-1:0]          mul_a;
    logic [CUT_W-1:0]           mul_b;
    logic [NUM_W-1:0]           product;
    logic [CUT_W:0]             cut_sum;
    logic signed [OFS_W-1:0]    offset;
    logic                       is_proton;
    logic                       is_pion;
    t_div_req                   div_req;
    logic                       div_done;
    logic [QUO_W-1:0]           div_quo;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign out_xfer   = r_out_valid && i_m_tready;
    assign in_e       = $signed(i_s_tdata[CALO_W-1:0]);

    // search midpoint and segment start
    assign mid_sum = {1'b0, r_lo_idx} + {1'b0, r_hi_idx};
    assign mid     = mid_sum[IDX_W:1];
    assign seg_lo  = r_lo_idx - IDX_W'(1);

    // shared multiplier, operands picked by sequencer step
    assign c0      = cut_at(seg_lo, r_pass);
    assign c1      = cut_at(r_lo_idx, r_pass);
    assign mul_a   = (r_state == S_MUL0) ? r_b : r_a;
    assign mul_b   = (r_state == S_MUL0) ? c0 : c1;
    assign product = NUM_W'(mul_a * mul_b);

    // divider request
    always_comb begin
        div_req.start    = (r_state == S_DIV_GO);
        div_req.dividend = r_acc[NUM_W-1:FRAC_SHIFT];
        div_req.divisor  = r_k;
    end

    ebpid_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // classification and offset
    always_comb begin
        cut_sum   = {1'b0, r_lo_cut} + {1'b0, r_hi_cut};
        offset    = OFS_W'(r_e) - $signed(OFS_W'(cut_sum >> 3));
        is_proton = ({1'b0, r_loss} >= {2'b0, r_lo_cut}) &&
                    ({1'b0, r_loss} <= {2'b0, r_hi_cut});
        is_pion   = ({1'b0, r_loss} < {2'b0, r_lo_cut});
    end

    // sequencer with registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pass      <= 1'b0;
        end else begin
            // the done step reloads the output register itself
            if (out_xfer && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_e    <= in_e;
                        r_u    <= i_s_tdata[ENERGY_W-1:0];
                        r_loss <= i_s_tdata[CALO_W +: LOSS_W];
                        r_pass <= 1'b0;
                        if (in_e[CALO_W-1]) begin
                            r_lo_cut <= '0;
                            r_hi_cut <= '0;
                            r_state  <= S_DONE;
                        end else if (in_e[ENERGY_W-1:0] <= energy_at(FIRST_IDX)) begin
                            r_lo_cut <= cut_at(FIRST_IDX, 1'b0);
                            r_hi_cut <= cut_at(FIRST_IDX, 1'b1);
                            r_state  <= S_DONE;
                        end else if (in_e[ENERGY_W-1:0] >= energy_at(LAST_IDX)) begin
                            r_lo_cut <= cut_at(LAST_IDX, 1'b0);
                            r_hi_cut <= cut_at(LAST_IDX, 1'b1);
                            r_state  <= S_DONE;
                        end else begin
                            r_lo_idx <= FIRST_IDX + IDX_W'(1);
                            r_hi_idx <= LAST_IDX;
                            r_state  <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    // smallest point index at or above the energy
                    if (r_lo_idx == r_hi_idx) begin
                        r_a     <= SPAN_W'(r_u - energy_at(seg_lo));
                        r_b     <= SPAN_W'(energy_at(r_lo_idx) - r_u);
                        r_k     <= step_at(r_lo_idx);
                        r_state <= S_MUL0;
                    end else if (r_u <= energy_at(mid)) begin
                        r_hi_idx <= mid;
                    end else begin
                        r_lo_idx <= mid + IDX_W'(1);
                    end
                end
                S_MUL0: begin
                    r_acc   <= product;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_acc   <= r_acc + product;
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        if (r_pass) begin
                            r_hi_cut <= div_quo[CUT_W-1:0];
                            r_state  <= S_DONE;
                        end else begin
                            r_lo_cut <= div_quo[CUT_W-1:0];
                            r_pass   <= 1'b1;
                            r_state  <= S_MUL0;
                        end
                    end
                end
                S_DONE: begin
                    // wait for the output register to drain
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {6'b0, offset, is_pion, is_proton};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// File: design/ebpid_checker.sv
// ----------------------------------------------------------------------------
// ebpid_checker
// port level checks of the band cut block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "energy_band_particle_id_top_macros.svh"

module ebpid_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    // stalled result holds
    `EBPID_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // a loss cannot be inside the band and below it at once
    `EBPID_ASSERT_NOW(a_flags_exclusive, i_clk, i_rst_n, o_m_tvalid, !(o_m_tdata[0] && o_m_tdata[1]))

    // the sequencer is busy in the cycle after an input transfer
    `EBPID_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // negative energy gives zero cuts, so never a pion
    `EBPID_ASSERT_NEXT(a_neg_no_pion, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tdata[14] && !o_m_tvalid, ##1 !o_m_tdata[1])

endmodule

bind energy_band_particle_id_top ebpid_checker u_ebpid_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
